// ----- rtl/core/olst_pkg.sv -----
// shared types, constants and fixed-point helpers of the online linear sgd trainer
package olst_pkg;

  localparam int unsigned Q_W        = 24;
  localparam int unsigned ERR_W      = 25;
  localparam int unsigned LR_W       = 17;
  localparam int unsigned COST_W     = 32;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned IDX_IN_W   = 4;
  localparam int unsigned MUL_A_W    = 34;
  localparam int unsigned MUL_B_W    = 26;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned RND_W      = PROD_W - FRAC_W;
  localparam int unsigned WIDE_W     = 48;

  localparam logic [LR_W-1:0]               LR_RESET   = 17'd6554;
  localparam logic signed [PROD_W-1:0]      RND_HALF   = 60'sd32768;
  localparam logic signed [WIDE_W-1:0]      WIDE_QMAX  = 48'sd8388607;
  localparam logic signed [WIDE_W-1:0]      WIDE_QMIN  = -48'sd8388608;
  localparam logic signed [Q_W-1:0]         Q_MAX      = 24'sh7FFFFF;
  localparam logic signed [Q_W-1:0]         Q_MIN      = 24'sh800000;

  typedef enum logic [0:0] {
    OP_LOAD    = 1'b0,
    OP_FEATURE = 1'b1
  } opcode_e;

  typedef enum logic [0:0] {
    CFG_LEARNING_RATE = 1'b0,
    CFG_BIAS          = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MUL_FW = 2'd0,
    MUL_SQ = 2'd1,
    MUL_FE = 2'd2,
    MUL_TL = 2'd3
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_ACC      = 4'd1,
    ST_PRED     = 4'd2,
    ST_SQR      = 4'd3,
    ST_COST     = 4'd4,
    ST_UPD_MUL1 = 4'd5,
    ST_UPD_RND  = 4'd6,
    ST_UPD_MUL2 = 4'd7,
    ST_UPD_WR   = 4'd8
  } olst_state_e;

  typedef struct packed {
    opcode_e                opcode;
    logic [IDX_IN_W-1:0]    index;
    logic signed [Q_W-1:0]  weight_value;
    logic signed [Q_W-1:0]  feature;
    logic signed [Q_W-1:0]  target;
    logic                   last;
  } olst_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0]  prediction;
    logic [COST_W-1:0]      cost;
  } olst_out_t;

  typedef struct packed {
    logic     load_we;
    logic     feat_cap;
    logic     feat_we;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_en;
    logic     pred_en;
    logic     out_load;
    logic     t_en;
    logic     w_upd;
    logic     sweep_clr;
    logic     sweep_inc;
    logic     sample_clr;
  } olst_cmd_t;

  typedef struct packed {
    logic pos_full;
    logic sweep_last;
  } olst_status_t;

  // round to nearest, ties toward plus infinity, dropping FRAC_W bits
  function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + RND_HALF;
    return s[PROD_W-1:FRAC_W];
  endfunction

  function automatic logic signed [Q_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > WIDE_QMAX) begin
      r = Q_MAX;
    end else if (v < WIDE_QMIN) begin
      r = Q_MIN;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/olst_ctrl.sv -----
// control state machine of the online linear sgd trainer
module olst_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  olst_pkg::opcode_e     in_opcode_i,
  input  logic                  in_last_i,
  output logic                  in_stall_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  input  olst_pkg::olst_status_t status_i,
  output olst_pkg::olst_cmd_t   cmd_o
);
  import olst_pkg::*;

  olst_state_e state_q, state_d;
  logic        last_q, last_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_opcode_i == OP_FEATURE)) begin
          last_d = in_last_i;
          if (!status_i.pos_full) begin
            state_d = ST_ACC;
          end else if (in_last_i) begin
            state_d = ST_PRED;
          end
        end
      end
      ST_ACC: begin
        state_d = last_q ? ST_PRED : ST_IDLE;
      end
      ST_PRED:     state_d = ST_SQR;
      ST_SQR:      state_d = ST_COST;
      ST_COST: begin
        if (out_free) begin
          state_d = ST_UPD_MUL1;
        end
      end
      ST_UPD_MUL1: state_d = ST_UPD_RND;
      ST_UPD_RND:  state_d = ST_UPD_MUL2;
      ST_UPD_MUL2: state_d = ST_UPD_WR;
      ST_UPD_WR: begin
        state_d = status_i.sweep_last ? ST_IDLE : ST_UPD_MUL1;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.mul_sel = MUL_FW;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode_i == OP_FEATURE) begin
            cmd_o.feat_cap = 1'b1;
            if (!status_i.pos_full) begin
              cmd_o.feat_we = 1'b1;
              cmd_o.mul_en  = 1'b1;
              cmd_o.mul_sel = MUL_FW;
            end
          end else begin
            cmd_o.load_we = 1'b1;
          end
        end
      end
      ST_ACC:  cmd_o.acc_en  = 1'b1;
      ST_PRED: cmd_o.pred_en = 1'b1;
      ST_SQR: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SQ;
      end
      ST_COST: begin
        if (out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.sweep_clr = 1'b1;
          out_valid_d     = 1'b1;
        end
      end
      ST_UPD_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_FE;
      end
      ST_UPD_RND:  cmd_o.t_en = 1'b1;
      ST_UPD_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_TL;
      end
      ST_UPD_WR: begin
        cmd_o.w_upd      = 1'b1;
        cmd_o.sweep_inc  = 1'b1;
        cmd_o.sample_clr = status_i.sweep_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/olst_datapath.sv -----
// weights, feature store, shared multiplier, accumulator and config registers
module olst_datapath #(
  parameter int unsigned NUM_FEATURES = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  olst_pkg::olst_in_t                   in_data_i,
  input  logic                                 cfg_we_i,
  input  olst_pkg::cfg_reg_e                   cfg_index_i,
  input  logic [olst_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  olst_pkg::olst_cmd_t                  cmd_i,
  output olst_pkg::olst_status_t               status_o,
  output olst_pkg::olst_out_t                  out_data_o
);
  import olst_pkg::*;

  localparam int unsigned IDX_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int unsigned POS_W = $clog2(NUM_FEATURES + 1);

  logic signed [Q_W-1:0]     weight_q [NUM_FEATURES];
  logic signed [Q_W-1:0]     feat_q   [NUM_FEATURES];
  logic [POS_W-1:0]          pos_q;
  logic [IDX_W-1:0]          sweep_q;
  logic signed [Q_W-1:0]     acc_q;
  logic signed [Q_W-1:0]     target_q;
  logic signed [Q_W-1:0]     pred_q;
  logic signed [ERR_W-1:0]   err_q;
  logic signed [MUL_A_W-1:0] t_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic [LR_W-1:0]           lr_q;
  logic signed [Q_W-1:0]     bias_q;
  olst_out_t                 out_q;

  logic [IDX_W-1:0]          pos_idx;
  logic [IDX_W-1:0]          w_addr;
  logic signed [Q_W-1:0]     w_rd;
  logic signed [Q_W-1:0]     feat_rd;
  logic                      load_ok;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [RND_W-1:0]   prod_rnd;
  logic signed [Q_W-1:0]     pred_d;
  logic signed [Q_W-1:0]     acc_d;
  logic signed [Q_W-1:0]     w_new;
  logic [COST_W-1:0]         cost_d;

  assign pos_idx  = pos_q[IDX_W-1:0];
  assign w_addr   = cmd_i.feat_we ? pos_idx : sweep_q;
  assign w_rd     = weight_q[w_addr];
  assign feat_rd  = feat_q[sweep_q];
  assign load_ok  = ({1'b0, in_data_i.index} < (IDX_IN_W + 1)'(NUM_FEATURES));
  assign prod_rnd = rnd16(prod_q);

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_FW: begin
        mul_a = MUL_A_W'(in_data_i.feature);
        mul_b = MUL_B_W'(w_rd);
      end
      MUL_SQ: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = MUL_B_W'(err_q);
      end
      MUL_FE: begin
        mul_a = MUL_A_W'(feat_rd);
        mul_b = {err_q, 1'b0};
      end
      MUL_TL: begin
        mul_a = t_q;
        mul_b = MUL_B_W'({1'b0, lr_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign acc_d  = sat24(WIDE_W'(acc_q) + WIDE_W'(sat24(WIDE_W'(prod_rnd))));
  assign pred_d = sat24(WIDE_W'(acc_q) + WIDE_W'(bias_q));
  assign w_new  = sat24(WIDE_W'(w_rd) - WIDE_W'(prod_rnd));
  assign cost_d = (prod_rnd[RND_W-1:COST_W] != '0) ? '1 : prod_rnd[COST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q   <= LR_RESET;
      bias_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LEARNING_RATE: lr_q   <= cfg_data_i[LR_W-1:0];
        CFG_BIAS:          bias_q <= cfg_data_i;
        default:           lr_q   <= lr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      acc_q   <= '0;
      sweep_q <= '0;
      for (int i = 0; i < NUM_FEATURES; i++) begin
        feat_q[i] <= '0;
      end
    end else begin
      if (cmd_i.feat_we) begin
        feat_q[pos_idx] <= in_data_i.feature;
        pos_q           <= pos_q + POS_W'(1);
      end
      if (cmd_i.acc_en) begin
        acc_q <= acc_d;
      end
      if (cmd_i.sweep_clr) begin
        sweep_q <= '0;
      end else if (cmd_i.sweep_inc) begin
        sweep_q <= sweep_q + IDX_W'(1);
      end
      if (cmd_i.sample_clr) begin
        pos_q <= '0;
        acc_q <= '0;
        for (int i = 0; i < NUM_FEATURES; i++) begin
          feat_q[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && load_ok) begin
      weight_q[in_data_i.index[IDX_W-1:0]] <= in_data_i.weight_value;
    end else if (cmd_i.w_upd) begin
      weight_q[sweep_q] <= w_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.feat_cap) begin
      target_q <= in_data_i.target;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.pred_en) begin
      pred_q <= pred_d;
      err_q  <= ERR_W'(pred_d) - ERR_W'(target_q);
    end
    if (cmd_i.t_en) begin
      t_q <= prod_rnd[MUL_A_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_q.prediction <= pred_q;
      out_q.cost       <= cost_d;
    end
  end

  assign status_o.pos_full   = (pos_q == POS_W'(NUM_FEATURES));
  assign status_o.sweep_last = (sweep_q == IDX_W'(NUM_FEATURES - 1));
  assign out_data_o          = out_q;

endmodule

// ----- rtl/core/online_linear_sgd_trainer_core.sv -----
// load beat: no stall; feature beat: stalled in ACC (not beyond NUM_FEATURES)
// last feature beat: ACC (none beyond NUM_FEATURES), PRED, SQR, result loaded in COST;
// input stalled to the end of the sweep, set by the shared multiplier doing the sweep
// one item at a time; a held result stalls the sweep until the output register frees
// reset is asynchronous: config to defaults, accumulator and feature store to zero,
// weights hold no value until loaded
module online_linear_sgd_trainer_core #(
  parameter int unsigned NUM_FEATURES = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  olst_pkg::olst_in_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output olst_pkg::olst_out_t              out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  olst_pkg::cfg_reg_e               cfg_index_i,
  input  logic [olst_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import olst_pkg::*;

  olst_cmd_t    cmd;
  olst_status_t status;

  assign cfg_ready_o = 1'b1;

  olst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .in_last_i   (in_data_i.last),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  olst_datapath #(
    .NUM_FEATURES (NUM_FEATURES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/core/olst_checker.sv -----
// port-level assertions of the online linear sgd trainer and their bind
module olst_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input olst_pkg::olst_in_t   in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input olst_pkg::olst_out_t  out_data_o
);
  import olst_pkg::*;

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_data_i.opcode == OP_LOAD) |=> !in_stall_o)
    else $error("load beat did not finish in one cycle");

  a_no_result_mid_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_data_i.opcode == OP_FEATURE) && !in_data_i.last |=> !$rose(out_valid_o))
    else $error("result raised by a non-final feature beat");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_data_i.opcode == OP_FEATURE) && in_data_i.last |=> in_stall_o)
    else $error("input not stalled while finishing a sample");

endmodule

bind online_linear_sgd_trainer_core olst_checker u_olst_checker (.*);

// ----- dv/testbench.sv -----
// self-checking testbench for the online linear sgd trainer core
`timescale 1ns / 1ps

module testbench;
  import olst_pkg::*;

  localparam int unsigned NF       = 4;
  localparam int unsigned DRAIN    = 60;
  localparam int unsigned LIMIT    = 400000;
  localparam int unsigned HOLD_LEN = 300;
  localparam int unsigned PHASE_N  = 240;
  localparam longint      QHI      = 64'sd8388607;
  localparam longint      QLO      = -64'sd8388608;
  localparam longint      COST_CAP = 64'sd4294967295;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  olst_in_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  olst_out_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_reg_e    cfg_index_i = CFG_LEARNING_RATE;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  online_linear_sgd_trainer_core #(.NUM_FEATURES(NF)) u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  olst_in_t    sample_beats[$];
  olst_out_t   scores_due[$];
  int unsigned beats_queued = 0;
  int unsigned beats_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  logic        calm = 1'b0;

  // neuron state as seen from outside
  logic [LR_W-1:0]       lr_q = LR_RESET;
  logic signed [Q_W-1:0] bias_q = '0;
  longint                w_m[NF];
  longint                f_m[NF];
  longint                acc_m = 0;
  int unsigned           pos_m = 0;

  function automatic longint sat_q(longint v);
    if (v > QHI) return QHI;
    if (v < QLO) return QLO;
    return v;
  endfunction

  function automatic longint round_q(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic void step_neuron(olst_in_t b);
    longint    f, pred, err, cost, t, d;
    olst_out_t e;
    f = longint'(b.feature);
    if (b.opcode == OP_LOAD) begin
      if (b.index < NF) w_m[b.index] = longint'(b.weight_value);
      return;
    end
    if (pos_m < NF) begin
      f_m[pos_m] = f;
      acc_m = sat_q(acc_m + sat_q(round_q(f * w_m[pos_m])));
      pos_m++;
    end
    if (!b.last) return;
    pred = sat_q(acc_m + longint'(bias_q));
    err = pred - longint'(b.target);
    cost = round_q(err * err);
    if (cost > COST_CAP) cost = COST_CAP;
    for (int i = 0; i < NF; i++) begin
      t = round_q(f_m[i] * 2 * err);
      d = round_q(t * longint'(lr_q));
      w_m[i] = sat_q(w_m[i] - d);
      f_m[i] = 0;
    end
    acc_m = 0;
    pos_m = 0;
    e.prediction = pred[Q_W-1:0];
    e.cost = cost[COST_W-1:0];
    scores_due.push_back(e);
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 100) $display("tb: mismatch at %0t: %s", $time, what);
  endtask

  function automatic logic signed [Q_W-1:0] rand_q();
    case ($urandom_range(0, 19))
      0: return Q_MAX;
      1: return Q_MIN;
      2, 3: return 24'($urandom);
      default: return 24'($urandom_range(0, 262143)) - 24'd131072;
    endcase
  endfunction

  function automatic void push_load(int unsigned idx, logic signed [Q_W-1:0] val);
    olst_in_t b;
    b.opcode = OP_LOAD;
    b.index = idx[IDX_IN_W-1:0];
    b.weight_value = val;
    b.feature = 24'($urandom);
    b.target = 24'($urandom);
    b.last = 1'($urandom);
    sample_beats.push_back(b);
    beats_queued++;
  endfunction

  function automatic void push_feature(logic signed [Q_W-1:0] f, logic signed [Q_W-1:0] tgt,
                                       logic last);
    olst_in_t b;
    b.opcode = OP_FEATURE;
    b.index = 4'($urandom);
    b.weight_value = 24'($urandom);
    b.feature = f;
    b.target = tgt;
    b.last = last;
    sample_beats.push_back(b);
    beats_queued++;
  endfunction

  function automatic void queue_sample();
    int unsigned k, n;
    k = $urandom_range(0, 19);
    if (k < 14) n = NF;
    else if (k < 17) n = $urandom_range(1, NF - 1);
    else n = $urandom_range(NF + 1, NF + 3);
    if ($urandom_range(0, 29) == 0) push_load($urandom_range(NF, 15), rand_q());
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0) push_load($urandom_range(0, 15), rand_q());
      push_feature(rand_q(), rand_q(), i == n - 1);
    end
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_LEARNING_RATE) lr_q = val[LR_W-1:0];
    else bias_q = val;
  endtask

  task automatic settle();
    do @(posedge clk_i); while (beats_taken != beats_queued || scores_due.size() != 0);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin : drive
    logic took;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      took = in_valid_i && !in_stall_o;
      if (took) begin
        step_neuron(in_data_i);
        beats_taken <= beats_taken + 1;
      end
      if (!in_valid_i || took) begin
        if (sample_beats.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
          in_valid_i <= 1'b1;
          in_data_i <= sample_beats.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the core backs up and stalls its input
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && beats_taken >= 400 * (holds_done + 1)) begin
      hold_left <= HOLD_LEN;
      holds_done <= holds_done + 1;
    end
  end

  // monitor
  always @(posedge clk_i) begin : watch
    olst_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (scores_due.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = scores_due.pop_front();
          if (out_data_o.prediction !== want.prediction)
            report_mismatch($sformatf("prediction %h, expected %h",
                                      out_data_o.prediction, want.prediction));
          if (out_data_o.cost !== want.cost)
            report_mismatch($sformatf("cost %h, expected %h", out_data_o.cost, want.cost));
        end
      end
      out_stall_i <= (hold_left != 0) || (!calm && $urandom_range(0, 99) < 8);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    logic [LR_W-1:0]       lr_set[6];
    logic signed [Q_W-1:0] bias_set[6];
    int unsigned           start;
    lr_set = '{17'd0, 17'd65536, 17'd131071, 17'd3277, 17'd6554, 17'($urandom_range(0, 65536))};
    bias_set = '{Q_MAX, Q_MIN, 24'sd0, 24'sh00C000, 24'($urandom), -24'sh010000};
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CFG_LEARNING_RATE, CFG_DATA_W'(LR_RESET));
    write_reg(CFG_BIAS, '0);
    push_load(0, Q_MAX);
    push_load(1, Q_MIN);
    push_load(2, 24'sd0);
    push_load(3, 24'sh010000);
    push_load(15, 24'sh123456);
    push_load(NF, Q_MIN);
    push_feature(Q_MAX, 24'sd0, 1'b0);
    push_feature(Q_MAX, 24'sd0, 1'b0);
    push_feature(Q_MIN, 24'sd0, 1'b0);
    push_feature(24'sh010000, Q_MIN, 1'b1);
    push_feature(Q_MIN, Q_MAX, 1'b1);
    for (int i = 0; i < NF + 2; i++) push_feature(24'sh008000, 24'sd0, i == NF + 1);
    push_feature(24'sh010000, 24'sd0, 1'b0);
    push_load(2, 24'sh020000);
    push_feature(24'sh010000, 24'sd0, 1'b0);
    push_feature(24'sh010000, 24'sh018000, 1'b1);
    push_feature(24'sd0, 24'sd0, 1'b1);
    settle();

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_LEARNING_RATE, CFG_DATA_W'(lr_set[p]));
      write_reg(CFG_BIAS, bias_set[p]);
      calm = (p == 2);
      start = beats_queued;
      for (int i = 0; i < NF; i++) push_load(i, 24'($urandom_range(0, 131071)) - 24'd65536);
      while (beats_queued - start < PHASE_N) queue_sample();
      settle();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
